// ===== rtl/lhq_pkg.sv =====
`default_nettype none
package lhq_pkg;

  // command codes carried on in_tuser
  typedef enum logic [1:0] {
    CMD_RECORD   = 2'd0,
    CMD_SNAPSHOT = 2'd1,
    CMD_CLEAR    = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC,
    ST_SWEEP,
    ST_DRAIN
  } state_t;

  localparam int unsigned CNT_W    = 32;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned NUM_Q    = 3;
  localparam int unsigned PCT_W    = 7;
  localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
  // p50, p90, p99
  localparam logic [PCT_W-1:0] PCT_Q [NUM_Q] = '{7'd50, 7'd90, 7'd99};

  // controller to datapath
  typedef struct packed {
    logic load;       // input transaction taken
    logic clear;      // zero all stores
    logic snap_init;  // latch rank targets, restart sweep
    logic rec_wr;     // bucket write-back and totals update
    logic sweep_rd;   // read next bucket of the sweep
    logic out_load;   // move snapshot into the output register
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic pipe_busy;
    logic out_free;
  } sts_t;

  // number of significant bits of v, by a five-step binary search
  function automatic logic [5:0] bit_len(input logic [31:0] v);
    logic [31:0] x;
    logic [4:0]  pos;
    x   = v;
    pos = '0;
    if (x[31:16] != 16'd0) begin
      pos[4] = 1'b1;
      x      = x >> 16;
    end
    if (x[15:8] != 8'd0) begin
      pos[3] = 1'b1;
      x      = x >> 8;
    end
    if (x[7:4] != 4'd0) begin
      pos[2] = 1'b1;
      x      = x >> 4;
    end
    if (x[3:2] != 2'd0) begin
      pos[1] = 1'b1;
      x      = x >> 2;
    end
    if (x[1]) begin
      pos[0] = 1'b1;
    end
    bit_len = (v == 32'd0) ? 6'd0 : {1'b0, pos} + 6'd1;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lhq_ram.sv =====
`default_nettype none
module lhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/lhq_ctrl.sv =====
`default_nettype none
module lhq_ctrl import lhq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [1:0] in_command,
  input  wire sts_t       sts,
  output ctl_t            ctl
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctl.load = 1'b1;
          case (cmd_t'(in_command))
            CMD_RECORD: begin
              state_nxt = ST_REC;
            end
            CMD_SNAPSHOT: begin
              ctl.snap_init = 1'b1;
              state_nxt     = ST_SWEEP;
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
            end
            default: begin
              // unused code, dropped
            end
          endcase
        end
      end
      ST_REC: begin
        ctl.rec_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SWEEP: begin
        ctl.sweep_rd = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy && sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/lhq_dpath.sv =====
`default_nettype none
module lhq_dpath import lhq_pkg::*; #(
  parameter int unsigned BUCKETS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ctl_t             ctl,
  output sts_t                  sts,
  input  wire logic [CNT_W-1:0] in_sample,
  input  wire logic             out_tready,
  output logic                  out_tvalid,
  output logic [CNT_W-1:0]      out_count,
  output logic [SUM_W-1:0]      out_sum,
  output logic [CNT_W-1:0]      out_max,
  output logic [CNT_W-1:0]      out_p50,
  output logic [CNT_W-1:0]      out_p90,
  output logic [CNT_W-1:0]      out_p99
);

  localparam int unsigned IDX_W = $clog2(BUCKETS);
  // cumulative count times the percent scale
  localparam int unsigned CUM_W = CNT_W + IDX_W + PCT_W;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(BUCKETS - 1);

  // totals
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] max_r, max_nxt;
  logic [SUM_W:0]   sum_wide;

  // record path
  logic [CNT_W-1:0] smp_r;
  logic [IDX_W-1:0] rec_idx_r;
  logic [IDX_W-1:0] bkt_in;
  logic [5:0]       len_in;
  logic [BUCKETS-1:0] vld_r, vld_nxt;
  logic [CNT_W-1:0] rd_data;
  logic [CNT_W-1:0] rec_cnt;
  logic [CNT_W-1:0] rec_inc;
  logic [IDX_W-1:0] ram_raddr;

  // sweep pipeline
  logic [IDX_W-1:0] swp_idx_r;
  logic             p1_r, p2_r;
  logic [IDX_W-1:0] p1_idx_r, p2_idx_r;
  logic [CNT_W-1:0] p1_cnt;
  logic [CUM_W-1:0] d100_r;
  logic [CUM_W-1:0] cum_r, cum_nxt;
  logic [CUM_W-1:0] tgt_r [NUM_Q];
  logic [NUM_Q-1:0] fnd_r;
  logic [CNT_W-1:0] bnd_r [NUM_Q];
  logic [CNT_W:0]   top_wide;
  logic [CNT_W-1:0] top_clamp;

  // output register
  logic             ovld_r;
  logic [CNT_W-1:0] o_cnt_r, o_max_r;
  logic [SUM_W-1:0] o_sum_r;
  logic [CNT_W-1:0] o_bnd_r [NUM_Q];

  // bucket of the incoming sample, top bucket saturates
  always_comb begin
    len_in = bit_len(in_sample);
    if (len_in > 6'(BUCKETS - 1)) begin
      bkt_in = IDX_TOP;
    end else begin
      bkt_in = IDX_W'(len_in);
    end
  end

  assign ram_raddr = ctl.sweep_rd ? swp_idx_r : bkt_in;

  lhq_ram #(
    .WIDTH (CNT_W),
    .DEPTH (BUCKETS)
  ) u_bkt_ram (
    .clk   (clk),
    .we    (ctl.rec_wr),
    .waddr (rec_idx_r),
    .wdata (rec_inc),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // never-written entries read as zero
  assign rec_cnt = vld_r[rec_idx_r] ? rd_data : '0;
  assign rec_inc = (rec_cnt == '1) ? rec_cnt : rec_cnt + CNT_W'(1);
  assign p1_cnt  = vld_r[p1_idx_r] ? rd_data : '0;

  always_comb begin
    vld_nxt  = vld_r;
    cnt_nxt  = cnt_r;
    sum_nxt  = sum_r;
    max_nxt  = max_r;
    sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(smp_r);
    if (ctl.clear) begin
      vld_nxt = '0;
      cnt_nxt = '0;
      sum_nxt = '0;
      max_nxt = '0;
    end else if (ctl.rec_wr) begin
      vld_nxt[rec_idx_r] = 1'b1;
      if (cnt_r != '1) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      sum_nxt = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      if (smp_r > max_r) begin
        max_nxt = smp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
      max_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
      sum_r <= sum_nxt;
      max_r <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      smp_r     <= in_sample;
      rec_idx_r <= bkt_in;
    end
  end

  // sweep control and pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_idx_r <= '0;
      p1_r      <= 1'b0;
      p2_r      <= 1'b0;
    end else begin
      if (ctl.snap_init) begin
        swp_idx_r <= '0;
      end else if (ctl.sweep_rd) begin
        swp_idx_r <= swp_idx_r + IDX_W'(1);
      end
      p1_r <= ctl.sweep_rd;
      p2_r <= p1_r;
    end
  end

  // upper bound of the bucket leaving the pipe, clamped to the maximum
  always_comb begin
    top_wide = ((CNT_W + 1)'(1) << p2_idx_r) - (CNT_W + 1)'(1);
    if (top_wide > {1'b0, max_r}) begin
      top_clamp = max_r;
    end else begin
      top_clamp = top_wide[CNT_W-1:0];
    end
  end

  assign cum_nxt = cum_r + d100_r;

  always_ff @(posedge clk) begin
    p1_idx_r <= swp_idx_r;
    p2_idx_r <= p1_idx_r;
    d100_r   <= CUM_W'(p1_cnt) * CUM_W'(PCT_SCALE);
    if (ctl.snap_init) begin
      cum_r <= '0;
      for (int q = 0; q < NUM_Q; q++) begin
        tgt_r[q] <= CUM_W'(cnt_r) * CUM_W'(PCT_Q[q]);
        fnd_r[q] <= 1'b0;
        bnd_r[q] <= '0;
      end
    end else if (p2_r) begin
      cum_r <= cum_nxt;
      for (int q = 0; q < NUM_Q; q++) begin
        // 100*cum >= count*q is the same test as cum >= ceil(count*q/100)
        if (!fnd_r[q] && (cum_nxt >= tgt_r[q])) begin
          fnd_r[q] <= 1'b1;
          bnd_r[q] <= top_clamp;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (ctl.out_load) begin
      ovld_r <= 1'b1;
    end else if (out_tready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      o_cnt_r <= cnt_r;
      o_sum_r <= sum_r;
      o_max_r <= max_r;
      for (int q = 0; q < NUM_Q; q++) begin
        o_bnd_r[q] <= bnd_r[q];
      end
    end
  end

  assign sts.sweep_last = (swp_idx_r == IDX_TOP);
  assign sts.pipe_busy  = p1_r | p2_r;
  assign sts.out_free   = !ovld_r || out_tready;

  assign out_tvalid = ovld_r;
  assign out_count  = o_cnt_r;
  assign out_sum    = o_sum_r;
  assign out_max    = o_max_r;
  assign out_p50    = o_bnd_r[0];
  assign out_p90    = o_bnd_r[1];
  assign out_p99    = o_bnd_r[2];

endmodule
`default_nettype wire

// ===== rtl/log2_latency_histogram_quantiles_top.sv =====
`default_nettype none
// Latency histogram with percentile readout. Each input transaction carries a
// command on in_tuser (0 record, 1 snapshot, 2 clear, 3 ignored) and a 32-bit
// sample in microseconds on in_tdata. A record files the sample in a log2
// bucket (bucket 0 is zero, bucket i spans 2^(i-1) to 2^i-1, the top bucket
// takes everything larger) and updates the saturating count, the saturating
// 64-bit sum and the maximum, by an accept followed by a read-modify-write of
// the bucket RAM. A clear zeroes all stores at once through per-bucket valid
// flags. A snapshot ends in a registered result: the bucket RAM is swept one
// entry a cycle through a three-stage accumulate-and-compare pipe, and p50,
// p90 and p99 are the upper bound of the first bucket whose running count
// reaches ceil(count*q/100), clamped to the maximum (zero when nothing was
// recorded). Only snapshots give an output transaction; a result waiting
// in the output register does not hold off records or clears, only the
// completion of the next snapshot.
module log2_latency_histogram_quantiles_top import lhq_pkg::*; #(
  parameter int unsigned BUCKETS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // [31:0] sample_us
  input  wire logic [1:0]   in_tuser,   // [1:0] command
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] sample_count, [95:32] sample_sum, [127:96] sample_max,
  // [159:128] median_bound, [191:160] p90_bound, [223:192] p99_bound
  output logic [223:0]      out_tdata
);

  ctl_t ctl;
  sts_t sts;

  logic [CNT_W-1:0] res_count;
  logic [SUM_W-1:0] res_sum;
  logic [CNT_W-1:0] res_max;
  logic [CNT_W-1:0] res_p50;
  logic [CNT_W-1:0] res_p90;
  logic [CNT_W-1:0] res_p99;

  // sequencing: accept, record write-back, bucket sweep, drain
  lhq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .sts        (sts),
    .ctl        (ctl)
  );

  // bucket RAM, totals, percentile search and output register
  lhq_dpath #(
    .BUCKETS (BUCKETS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .sts        (sts),
    .in_sample  (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_count  (res_count),
    .out_sum    (res_sum),
    .out_max    (res_max),
    .out_p50    (res_p50),
    .out_p90    (res_p90),
    .out_p99    (res_p99)
  );

  // fields packed from the lowest bit up
  assign out_tdata = {res_p99, res_p90, res_p50, res_max, res_sum, res_count};

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lhq_pkg::*;

  localparam int unsigned NBUCKETS     = 32;
  // command code with no meaning, the block should drop it silently
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam int unsigned MAX_CYCLES   = 400000;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned RANDOM_ITEMS = 1400;
  localparam int unsigned NUM_PHASES   = 4;

  // result layout, lowest field in the lowest bits of out_tdata
  typedef struct packed {
    logic [31:0] p99;
    logic [31:0] p90;
    logic [31:0] p50;
    logic [31:0] peak;
    logic [63:0] sum;
    logic [31:0] count;
  } snapshot_t;

  // shadow histogram plus the queue of snapshots still owed by the block
  class histogram_checker;
    logic [31:0] tally [NBUCKETS];
    logic [31:0] count;
    logic [63:0] sum;
    logic [31:0] peak;
    snapshot_t   owed [$];
    int unsigned errors;

    function new();
      wipe();
      errors = 0;
    endfunction

    function void wipe();
      foreach (tally[i]) tally[i] = '0;
      count = '0;
      sum   = '0;
      peak  = '0;
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("[%0t] %s", $time, msg);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got)
        flag($sformatf("%s mismatch: expected %0d, got %0d", field, want, got));
    endfunction

    // upper bound of the first bin whose running total reaches ceil(count*q/100)
    function logic [31:0] rank_bound(int unsigned q);
      logic [63:0] rank;
      logic [63:0] cum;
      logic [63:0] bound;
      bit          found;
      rank  = ({32'd0, count} * q + 64'd99) / 64'd100;
      cum   = '0;
      bound = '0;
      found = 1'b0;
      for (int i = 0; i < NBUCKETS; i++) begin
        cum = cum + {32'd0, tally[i]};
        if (!found && cum >= rank) begin
          found = 1'b1;
          bound = (i == 0) ? 64'd0 : (64'd1 << i) - 64'd1;
        end
      end
      if (bound > {32'd0, peak}) bound = {32'd0, peak};
      return bound[31:0];
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] smp);
      int unsigned idx;
      snapshot_t   s;
      case (cmd)
        CMD_RECORD: begin
          idx = 0;
          for (int b = 0; b < 32; b++) if (smp[b]) idx = b + 1;
          if (idx > NBUCKETS - 1) idx = NBUCKETS - 1;
          if (tally[idx] != '1) tally[idx] = tally[idx] + 32'd1;
          if (count != '1) count = count + 32'd1;
          if (sum > 64'hFFFF_FFFF_FFFF_FFFF - {32'd0, smp}) sum = '1;
          else sum = sum + {32'd0, smp};
          if (smp > peak) peak = smp;
        end
        CMD_SNAPSHOT: begin
          s.count = count;
          s.sum   = sum;
          s.peak  = peak;
          if (count == '0) begin
            s.p50 = '0;
            s.p90 = '0;
            s.p99 = '0;
          end else begin
            s.p50 = rank_bound(50);
            s.p90 = rank_bound(90);
            s.p99 = rank_bound(99);
          end
          owed.insert(owed.size(), s);
        end
        CMD_CLEAR: wipe();
        default: ;
      endcase
    endfunction

    function void check_snapshot(snapshot_t got);
      snapshot_t want;
      if (owed.size() == 0) begin
        flag($sformatf("result transaction with nothing expected, count %0d", got.count));
        return;
      end
      want = owed.pop_front();
      compare("sample_count", {32'd0, want.count}, {32'd0, got.count});
      compare("sample_sum", want.sum, got.sum);
      compare("sample_max", {32'd0, want.peak}, {32'd0, got.peak});
      compare("median_bound", {32'd0, want.p50}, {32'd0, got.p50});
      compare("p90_bound", {32'd0, want.p90}, {32'd0, got.p90});
      compare("p99_bound", {32'd0, want.p99}, {32'd0, got.p99});
    endfunction
  endclass

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata   = '0;   // [31:0] sample_us
  logic [1:0]   in_tuser   = '0;   // [1:0] command
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // [31:0] sample_count, [95:32] sample_sum, [127:96] sample_max,
  // [159:128] median_bound, [191:160] p90_bound, [223:192] p99_bound
  logic [223:0] out_tdata;

  // idling odds in percent, changed per phase
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycles         = 0;

  histogram_checker chk = new();

  log2_latency_histogram_quantiles_top #(
    .BUCKETS (NBUCKETS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 10 ns clock
  initial begin
    forever #5 clk = ~clk;
  end

  // both channels sampled at the rising edge, with the watchdog alongside
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && in_tvalid && in_tready) chk.note_command(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) chk.check_snapshot(snapshot_t'(out_tdata));
    if (cycles >= MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
  end

  // one input transaction: optional idle gap, then hold valid until taken;
  // entered and left on a falling edge
  task automatic send(input logic [1:0] cmd, input logic [31:0] smp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tuser  <= 2'($urandom);   // junk on the bus while idle
      in_tdata  <= $urandom;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned len;
    logic [31:0] v;

    // synchronous reset, held from time zero and released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty histogram, the ignored code, bucket edges, clearing
    send(CMD_SNAPSHOT, 32'd0);
    send(CMD_UNUSED, 32'hFFFF_FFFF);
    send(CMD_SNAPSHOT, 32'hFFFF_FFFF);
    send(CMD_RECORD, 32'd0);
    send(CMD_SNAPSHOT, 32'd0);
    send(CMD_RECORD, 32'd1);
    send(CMD_RECORD, 32'd2);
    send(CMD_RECORD, 32'd3);
    send(CMD_RECORD, 32'h3FFF_FFFF);
    send(CMD_RECORD, 32'h4000_0000);
    send(CMD_RECORD, 32'h7FFF_FFFF);
    send(CMD_RECORD, 32'h8000_0000);
    send(CMD_RECORD, 32'hFFFF_FFFF);
    send(CMD_SNAPSHOT, 32'd0);
    send(CMD_UNUSED, 32'd0);
    send(CMD_SNAPSHOT, 32'h5555_AAAA);
    send(CMD_CLEAR, 32'hFFFF_FFFF);
    send(CMD_SNAPSHOT, 32'd0);
    send(CMD_RECORD, 32'd100);
    send(CMD_RECORD, 32'd1000);
    send(CMD_RECORD, 32'd7);
    send(CMD_SNAPSHOT, 32'd0);
    send(CMD_CLEAR, 32'd0);
    send(CMD_RECORD, 32'hFFFF_FFFF);
    send(CMD_SNAPSHOT, 32'd0);

    // random: mostly records with spread bit lengths, snapshots now and then,
    // the odd clear and ignored code; one idling profile per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 7;
          recv_stall_pct = 7;
        end
      endcase
      for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) begin
        pick = $urandom_range(999);
        if (pick < 15) begin
          send(CMD_CLEAR, $urandom);
        end else if (pick < 25) begin
          send(CMD_UNUSED, $urandom);
        end else if (pick < 95) begin
          send(CMD_SNAPSHOT, $urandom);
        end else begin
          // pick the bit length first so every bucket gets traffic
          len = $urandom_range(32);
          v   = $urandom;
          if (len == 0) v = '0;
          else begin
            if (len < 32) v = v & ((32'd1 << len) - 32'd1);
            v[len-1] = 1'b1;
          end
          send(CMD_RECORD, v);
        end
      end
    end

    in_tvalid      <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // drain, then keep watching the result channel for anything stray
    while (chk.owed.size() != 0) @(posedge clk);
    repeat (2 * NBUCKETS) @(posedge clk);
    if (chk.owed.size() != 0)
      chk.flag($sformatf("%0d snapshot results never arrived", chk.owed.size()));

    if (chk.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
